FILE: rtl/ofc_pkg.sv
// Shared types, constants and helpers for the occupancy frontier cell test.
package ofc_pkg;

  localparam int IDX_W     = 16;
  localparam int VAL_W     = 8;
  localparam int REG_W     = 9;
  localparam int CFG_IDX_W = 1;

  // The query inspects a 5x5 window centred on the queried cell.
  localparam int WIN       = 5;
  localparam int WIN_CELLS = WIN * WIN;
  localparam int WIN_POS_W = $clog2(WIN_CELLS);
  localparam int WIN_CTR   = (WIN_CELLS - 1) / 2;
  localparam int WIN_HALF  = WIN / 2;

  localparam int NB_CNT_W      = 4;
  localparam int MIN_UNKNOWN_NB = 3;

  localparam logic signed [VAL_W-1:0] VAL_UNKNOWN = -8'sd1;
  localparam logic signed [VAL_W-1:0] VAL_FREE    = 8'sd0;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  typedef enum logic [1:0] {
    CLS_FREE     = 2'd0,
    CLS_UNKNOWN  = 2'd1,
    CLS_OCCUPIED = 2'd2
  } cls_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } ofc_state_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] dividend;
  } div_req_t;

  function automatic cls_t cls_of_value(input logic signed [VAL_W-1:0] v);
    cls_t c;
    if (v == VAL_UNKNOWN) begin
      c = CLS_UNKNOWN;
    end else if (v == VAL_FREE) begin
      c = CLS_FREE;
    end else begin
      c = CLS_OCCUPIED;
    end
    return c;
  endfunction

endpackage

FILE: rtl/ofc_in_if.sv
// Input channel interface: command items with valid/ready handshake.
interface ofc_in_if;
  import ofc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [IDX_W-1:0]        cell_index;
  logic signed [VAL_W-1:0] cell_value;

  modport source (output valid, cmd, cell_index, cell_value, input ready);
  modport sink   (input valid, cmd, cell_index, cell_value, output ready);
endinterface

FILE: rtl/ofc_out_if.sv
// Result channel interface: frontier flags with valid/ready handshake.
interface ofc_out_if;
  import ofc_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] queried_index;
  logic             frontier;
  logic             bad_index;

  modport source (output valid, queried_index, frontier, bad_index, input ready);
  modport sink   (input valid, queried_index, frontier, bad_index, output ready);
endinterface

FILE: rtl/ofc_cell_mem.sv
// Single-port cell class store with a registered read.
module ofc_cell_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  ofc_pkg::cls_t wdata,
  output ofc_pkg::cls_t rdata
);
  import ofc_pkg::*;

  cls_t mem_r [DEPTH];
  cls_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: rtl/ofc_divider.sv
// Restoring divider, one quotient bit per cycle, splitting an index into row and column.
module ofc_divider #(
  parameter int SIDE_W = 9
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ofc_pkg::div_req_t          req,
  input  logic [SIDE_W-1:0]          divisor,
  output logic                       done,
  output logic [ofc_pkg::IDX_W-1:0]  quotient,
  output logic [SIDE_W-1:0]          remainder
);
  import ofc_pkg::*;

  localparam int CNT_W = $clog2(IDX_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  quo_r;
  logic [SIDE_W-1:0] rem_r;
  logic [SIDE_W-1:0] dvs_r;

  logic [SIDE_W:0]   trial;
  logic              fits;
  logic [SIDE_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[IDX_W-1]};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? SIDE_W'(trial - {1'b0, dvs_r}) : SIDE_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(IDX_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[IDX_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule

FILE: rtl/ofc_frontier_eval.sv
// Frontier decision over a 5x5 mask of unknown cells around the queried cell.
module ofc_frontier_eval (
  input  logic [ofc_pkg::WIN_CELLS-1:0] unk_mask,
  input  logic                          centre_free,
  output logic                          frontier
);
  import ofc_pkg::*;

  logic [8:0] hit;

  // Each ring neighbour counts the unknown cells of its own 3x3 surround.
  for (genvar ny = 1; ny <= 3; ny++) begin : g_row
    for (genvar nx = 1; nx <= 3; nx++) begin : g_col
      localparam int P = ny * WIN + nx;
      localparam int H = (ny - 1) * 3 + (nx - 1);
      if (P == WIN_CTR) begin : g_ctr
        assign hit[H] = 1'b0;
      end else begin : g_nb
        logic [NB_CNT_W-1:0] cnt;
        assign cnt = NB_CNT_W'(unk_mask[P-WIN-1]) + NB_CNT_W'(unk_mask[P-WIN])
                   + NB_CNT_W'(unk_mask[P-WIN+1]) + NB_CNT_W'(unk_mask[P-1])
                   + NB_CNT_W'(unk_mask[P+1])     + NB_CNT_W'(unk_mask[P+WIN-1])
                   + NB_CNT_W'(unk_mask[P+WIN])   + NB_CNT_W'(unk_mask[P+WIN+1]);
        assign hit[H] = unk_mask[P] && (cnt >= NB_CNT_W'(MIN_UNKNOWN_NB));
      end
    end
  end

  assign frontier = centre_free && (|hit);
endmodule

FILE: rtl/occupancy_frontier_cell_test.sv
// Top level of the occupancy grid frontier cell test.
//
//   Channel  Direction  Handshake          Item contents
//   in_ch    sink       valid/ready        cmd, cell_index, cell_value
//   out_ch   source     valid/ready        queried_index, frontier, bad_index
//   cfg_*    sink       cfg_we, no ready   cfg_index selects width or height
//
// A load item is written straight into the cell store in the cycle it is taken.
// A query item holds the input while the divider splits the index into row and
// column, the 5x5 window is read through the single store port, the last read
// returns and the result is loaded; a bad index skips the window reads. Reset
// is synchronous and active low; it clears control state and sets both sides
// to 256, not the store. A stalled result waits in the output register while
// items are still taken; a finished query waits for it to empty.
module occupancy_frontier_cell_test #(
  parameter int MAX_CELLS = 65536,
  parameter int MAX_SIDE  = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ofc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ofc_pkg::REG_W-1:0]       cfg_data,
  ofc_in_if.sink                          in_ch,
  ofc_out_if.source                       out_ch
);
  import ofc_pkg::*;

  // Side, product and address widths all follow from the two limits.
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CW     = 2 * SIDE_W;
  localparam int SW     = CW + 2;
  localparam int XW     = SIDE_W + 2;
  localparam int AW     = $clog2(MAX_CELLS);

  // Configuration registers and the clamped grid sides.
  logic [REG_W-1:0]  grid_width_r;
  logic [REG_W-1:0]  grid_height_r;
  logic [SIDE_W-1:0] side_w;
  logic [SIDE_W-1:0] side_h;
  logic [CW-1:0]     cells_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= REG_W'(256);
      grid_height_r <= REG_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A side of zero counts as one; anything above the limit counts as the limit.
  always_comb begin
    if (grid_width_r == '0) begin
      side_w = SIDE_W'(1);
    end else if (32'(grid_width_r) > MAX_SIDE) begin
      side_w = SIDE_W'(MAX_SIDE);
    end else begin
      side_w = SIDE_W'(grid_width_r);
    end
    if (grid_height_r == '0) begin
      side_h = SIDE_W'(1);
    end else if (32'(grid_height_r) > MAX_SIDE) begin
      side_h = SIDE_W'(MAX_SIDE);
    end else begin
      side_h = SIDE_W'(grid_height_r);
    end
  end

  // The cell count is only needed once the divider has finished, so a register
  // after the multiplier is always up to date by then.
  always_ff @(posedge clk) begin
    cells_r <= CW'(side_w) * CW'(side_h);
  end

  // Control state and sequencer registers.
  ofc_state_t state_r, state_nxt;

  logic                    in_acc;
  logic                    is_query;
  logic                    div_done;
  logic [IDX_W-1:0]        div_quo;
  logic [SIDE_W-1:0]       div_rem;
  div_req_t                div_req;

  logic [IDX_W-1:0]        idx_r;
  logic                    bad_r;
  logic                    bad_now;
  logic signed [XW-1:0]    x0_r;
  logic signed [XW-1:0]    xx_r;
  logic signed [XW-1:0]    yy_r;
  logic [2:0]              wx_r;
  logic [WIN_POS_W-1:0]    pos_r;
  logic signed [SW-1:0]    row_addr_r;
  logic signed [SW-1:0]    scan_addr;
  logic                    in_grid;
  logic                    in_store;
  logic                    rd_en;
  logic                    pend_r;
  logic [WIN_POS_W-1:0]    pend_pos_r;
  logic [WIN_CELLS-1:0]    mask_r;
  logic                    centre_free_r;
  logic                    front;

  logic                    ld_we;
  logic [AW-1:0]           mem_addr;
  cls_t                    rd_cls;

  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic                    out_front_r;
  logic                    out_bad_r;

  // FSM output decode.
  logic in_ready_c;
  logic scan_c;
  logic out_load_c;

  assign in_acc   = in_ch.valid && in_ready_c;
  assign is_query = (in_ch.cmd == CMD_QUERY);

  // A query is bad when it lies past the grid or past the store.
  assign bad_now = (32'(idx_r) >= 32'(cells_r)) || (32'(idx_r) >= 32'(MAX_CELLS));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && is_query) state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = bad_now ? ST_OUT : ST_SCAN;
      ST_SCAN:  if (pos_r == WIN_POS_W'(WIN_CELLS - 1)) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_c = 1'b0;
    scan_c     = 1'b0;
    out_load_c = 1'b0;
    case (state_r)
      ST_IDLE: in_ready_c = 1'b1;
      ST_SCAN: scan_c     = 1'b1;
      ST_OUT:  out_load_c = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Row and column of the queried cell come from the divider.
  assign div_req.start    = in_acc && is_query;
  assign div_req.dividend = in_ch.cell_index;

  ofc_divider #(.SIDE_W(SIDE_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .divisor   (side_w),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Window scan: the window starts two rows up and two columns left of the cell.
  // Cells outside the grid or the store are skipped and read as not unknown.
  assign scan_addr = row_addr_r + SW'(wx_r);
  assign in_grid   = !xx_r[XW-1] && !yy_r[XW-1]
                     && (xx_r < $signed({2'b00, side_w}))
                     && (yy_r < $signed({2'b00, side_h}));
  assign in_store  = !scan_addr[SW-1] && (32'($unsigned(scan_addr)) < 32'(MAX_CELLS));
  assign rd_en     = scan_c && in_grid && in_store;

  always_ff @(posedge clk) begin
    if (in_acc && is_query) begin
      idx_r <= in_ch.cell_index;
    end
    if (state_r == ST_DIV && div_done) begin
      bad_r      <= bad_now;
      x0_r       <= $signed(XW'(div_rem)) - XW'(WIN_HALF);
      xx_r       <= $signed(XW'(div_rem)) - XW'(WIN_HALF);
      yy_r       <= $signed(XW'(div_quo)) - XW'(WIN_HALF);
      row_addr_r <= $signed(SW'(idx_r)) - $signed(SW'(WIN_HALF) * SW'(side_w))
                    - SW'(WIN_HALF);
      wx_r       <= '0;
      pos_r      <= '0;
    end else if (scan_c) begin
      pos_r <= pos_r + WIN_POS_W'(1);
      if (wx_r == 3'(WIN - 1)) begin
        wx_r       <= '0;
        xx_r       <= x0_r;
        yy_r       <= yy_r + XW'(1);
        row_addr_r <= row_addr_r + SW'(side_w);
      end else begin
        wx_r <= wx_r + 3'd1;
        xx_r <= xx_r + XW'(1);
      end
    end
  end

  // Read data arrives in the cycle after the request and lands in the window mask.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    pend_pos_r <= pos_r;
    if (state_r == ST_DIV && div_done) begin
      mask_r        <= '0;
      centre_free_r <= 1'b0;
    end else if (pend_r) begin
      mask_r[pend_pos_r] <= (rd_cls == CLS_UNKNOWN);
      if (pend_pos_r == WIN_POS_W'(WIN_CTR)) begin
        centre_free_r <= (rd_cls == CLS_FREE);
      end
    end
  end

  // Loads go to the store in the cycle they are taken, unless past its end.
  assign ld_we    = in_acc && !is_query && (32'(in_ch.cell_index) < 32'(MAX_CELLS));
  assign mem_addr = scan_c ? AW'($unsigned(scan_addr)) : AW'(in_ch.cell_index);

  ofc_cell_mem #(.DEPTH(MAX_CELLS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (ld_we),
    .re    (rd_en),
    .addr  (mem_addr),
    .wdata (cls_of_value(in_ch.cell_value)),
    .rdata (rd_cls)
  );

  ofc_frontier_eval u_eval (
    .unk_mask    (mask_r),
    .centre_free (centre_free_r),
    .frontier    (front)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_c) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_c) begin
      out_idx_r   <= idx_r;
      out_front_r <= !bad_r && front;
      out_bad_r   <= bad_r;
    end
  end

  assign in_ch.ready          = in_ready_c;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.queried_index = out_idx_r;
  assign out_ch.frontier      = out_front_r;
  assign out_ch.bad_index     = out_bad_r;
endmodule

FILE: rtl/ofc_checker.sv
// Port-level checks for the frontier cell test, bound to the top level.
module ofc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_cmd,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ofc_pkg::IDX_W-1:0]  out_queried_index,
  input logic                       out_frontier,
  input logic                       out_bad_index
);
  import ofc_pkg::*;

  // A flagged index never reports a frontier.
  a_bad_not_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_bad_index && out_frontier))
    else $error("bad_index and frontier both set");

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_queried_index)
      && $stable(out_frontier) && $stable(out_bad_index))
    else $error("result changed while stalled");

  // A query occupies the block: no item is taken in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_QUERY) |=> !in_ready)
    else $error("item taken right after a query");

  // A query needs the divider, so its result cannot appear in the next cycle.
  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_QUERY) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind occupancy_frontier_cell_test ofc_checker u_ofc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_cmd            (in_ch.cmd),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_queried_index (out_ch.queried_index),
  .out_frontier      (out_ch.frontier),
  .out_bad_index     (out_ch.bad_index)
);

FILE: tb/ofc_frontier_checker.sv
// Checker for the frontier cell test: predicts every query result and compares it.
module ofc_frontier_checker #(
  parameter int MAX_CELLS = 65536,
  parameter int MAX_SIDE  = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ofc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ofc_pkg::REG_W-1:0]     cfg_data,
  ofc_in_if                             in_ch,
  ofc_out_if                            out_ch,
  output int                            mismatches,
  output int                            awaited
);
  import ofc_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] queried_index;
    logic             frontier;
    logic             bad_index;
  } flag_t;

  cls_t           cell_class [MAX_CELLS];
  logic [REG_W-1:0] width_reg;
  logic [REG_W-1:0] height_reg;
  flag_t          flags_due [$];

  function automatic int side_of(input logic [REG_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_SIDE) return MAX_SIDE;
    return int'(r);
  endfunction

  function automatic cls_t class_of(input logic signed [VAL_W-1:0] v);
    if (v == VAL_UNKNOWN) return CLS_UNKNOWN;
    if (v == VAL_FREE) return CLS_FREE;
    return CLS_OCCUPIED;
  endfunction

  // Off-grid cells and cells beyond the store never count as unknown.
  function automatic bit unknown_at(input int x, input int y, input int w, input int h);
    int idx;
    if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
    idx = y * w + x;
    if (idx >= MAX_CELLS) return 1'b0;
    return cell_class[IDX_W'(idx)] == CLS_UNKNOWN;
  endfunction

  function automatic int unknown_around(input int x, input int y, input int w, input int h);
    int n;
    n = 0;
    for (int dy = -1; dy <= 1; dy++)
      for (int dx = -1; dx <= 1; dx++)
        if ((dx != 0 || dy != 0) && unknown_at(x + dx, y + dy, w, h)) n++;
    return n;
  endfunction

  function automatic flag_t frontier_flag(input logic [IDX_W-1:0] idx);
    flag_t f;
    int    w, h, x, y;
    w = side_of(width_reg);
    h = side_of(height_reg);
    f.queried_index = idx;
    f.frontier      = 1'b0;
    f.bad_index     = 1'b0;
    if (int'(idx) >= w * h || int'(idx) >= MAX_CELLS) begin
      f.bad_index = 1'b1;
      return f;
    end
    if (cell_class[idx] == CLS_FREE) begin
      x = int'(idx) % w;
      y = int'(idx) / w;
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++)
          if ((dx != 0 || dy != 0) && unknown_at(x + dx, y + dy, w, h) &&
              unknown_around(x + dx, y + dy, w, h) >= MIN_UNKNOWN_NB)
            f.frontier = 1'b1;
    end
    return f;
  endfunction

  always @(posedge clk) begin
    flag_t got, want;
    if (!rst_n) begin
      flags_due.delete();
      width_reg  = REG_W'(MAX_SIDE);
      height_reg = REG_W'(MAX_SIDE);
      mismatches = 0;
      awaited    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.queried_index, out_ch.frontier, out_ch.bad_index};
        if (flags_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got index %h frontier %b bad %b",
                   $time, got.queried_index, got.frontier, got.bad_index);
          mismatches++;
        end else begin
          want = flags_due.pop_front();
          if (got.queried_index !== want.queried_index) begin
            $display("%0t: queried_index expected %h got %h",
                     $time, want.queried_index, got.queried_index);
            mismatches++;
          end
          if (got.frontier !== want.frontier) begin
            $display("%0t: frontier for index %h expected %b got %b",
                     $time, want.queried_index, want.frontier, got.frontier);
            mismatches++;
          end
          if (got.bad_index !== want.bad_index) begin
            $display("%0t: bad_index for index %h expected %b got %b",
                     $time, want.queried_index, want.bad_index, got.bad_index);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  width_reg  = cfg_data;
          CFG_GRID_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.cmd == CMD_LOAD) begin
          if (int'(in_ch.cell_index) < MAX_CELLS)
            cell_class[in_ch.cell_index] = class_of(in_ch.cell_value);
        end else begin
          flags_due.insert(flags_due.size(), frontier_flag(in_ch.cell_index));
        end
      end
      awaited = flags_due.size();
    end
  end

endmodule

FILE: tb/occupancy_frontier_cell_test_tb.sv
// Testbench top: drives grid loads, frontier queries and grid settings into the block.
module occupancy_frontier_cell_test_tb;
  import ofc_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  ofc_in_if  in_ch ();
  ofc_out_if out_ch ();

  int mismatches;
  int awaited;

  // Cells that have been loaded at least once. The store is not cleared by
  // reset, so a query is only issued when every in-grid cell of its 5x5
  // window has been written; otherwise the block would read undefined data.
  bit written [65536];

  // Effective grid sides, after the block's clamping of 0 and of large values.
  int grid_w, grid_h;

  bit gaps_on, stalls_on;
  int stall_left;
  int items_sent, queries_sent, settings_run;

  occupancy_frontier_cell_test DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ofc_frontier_checker frontier_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always #5 clk = ~clk;

  // Result side back-pressure: random stall bursts while enabled.
  always @(negedge clk) begin
    if (!stalls_on) begin
      out_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ch.ready = 1'b0;
      stall_left   = $urandom_range(0, 7);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Generous overall limit; a correct run finishes well inside it.
  initial begin
    #3000000;
    $display("occupancy_frontier_cell_test_tb: done, errors");
    $finish;
  end

  function automatic bit on_grid(input int x, input int y);
    return x >= 0 && y >= 0 && x < grid_w && y < grid_h;
  endfunction

  // Mostly unknown and free cells, so that frontiers are common; an occupied
  // cell takes any value other than 0 and -1, which covers both extremes.
  function automatic logic [VAL_W-1:0] pick_value(input int free_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < free_pct) return VAL_FREE;
    if (r < free_pct + 45) return VAL_UNKNOWN;
    return VAL_W'($urandom_range(1, 254));
  endfunction

  // Offers one item at the falling edge, with a random gap in front of it when
  // gaps are enabled, and holds it until the block accepts it at a rising edge.
  // Back-to-back items keep valid high, so it is never lowered and raised in
  // one step.
  task automatic push_item(input cmd_t op, input int idx, input logic [VAL_W-1:0] v);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.cmd        = op;
    in_ch.cell_index = IDX_W'(idx);
    in_ch.cell_value = v;
    do @(posedge clk); while (!in_ch.ready);
    if (op == CMD_LOAD) begin
      written[IDX_W'(idx)] = 1'b1;
    end else begin
      queries_sent++;
    end
    items_sent++;
  endtask

  // Queries a cell only if its whole in-grid window is loaded; a bad index
  // reads nothing and is always allowed.
  task automatic query_if_ready(input int idx);
    int x, y;
    bit ready_to_read;
    ready_to_read = 1'b1;
    if (idx < grid_w * grid_h) begin
      x = idx % grid_w;
      y = idx / grid_w;
      for (int dy = -2; dy <= 2; dy++)
        for (int dx = -2; dx <= 2; dx++)
          if (on_grid(x + dx, y + dy) && !written[IDX_W'((y + dy) * grid_w + x + dx)])
            ready_to_read = 1'b0;
    end
    if (ready_to_read) push_item(CMD_QUERY, idx, VAL_W'($urandom()));
  endtask

  // Lowers valid and waits until every query has been answered. A load gives no
  // result, and a query keeps the block busy after it is taken, so a further
  // hold-off lets the block fall idle before the grid registers change.
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic set_grid(input logic [REG_W-1:0] wr, input logic [REG_W-1:0] hr);
    settle();
    cfg_we    = 1'b1;
    cfg_index = CFG_GRID_WIDTH;
    cfg_data  = wr;
    @(negedge clk);
    cfg_index = CFG_GRID_HEIGHT;
    cfg_data  = hr;
    @(negedge clk);
    cfg_we = 1'b0;
    grid_w = (wr == 0) ? 1 : (wr > 256) ? 256 : int'(wr);
    grid_h = (hr == 0) ? 1 : (hr > 256) ? 256 : int'(hr);
    settings_run++;
  endtask

  // One grid setting with its own traffic. Small grids are loaded whole and
  // then see a mix of queries, reloads, bad indexes and stray loads anywhere in
  // the store. Large grids are worked a window at a time: load the 5x5 window
  // around a random centre, query it, reload single cells and query again, and
  // query neighbours whose own windows happen to be loaded, at times also a bad index.
  task automatic grid_phase(input logic [REG_W-1:0] wr, input logic [REG_W-1:0] hr,
                            input bit gaps, input bit stalls, input int n_items);
    int start, cells, c, cx, cy, nx, ny, k;
    set_grid(wr, hr);
    gaps_on   = gaps;
    stalls_on = stalls;
    start     = items_sent;
    cells     = grid_w * grid_h;
    if (cells <= 100) begin
      for (k = 0; k < cells; k++) push_item(CMD_LOAD, k, pick_value(35));
      while (items_sent - start < n_items) begin
        k = $urandom_range(0, 99);
        if (k < 55) begin
          query_if_ready($urandom_range(0, cells - 1));
        end else if (k < 65) begin
          push_item(CMD_QUERY, $urandom_range(cells, 65535), VAL_W'($urandom()));
        end else if (k < 90) begin
          push_item(CMD_LOAD, $urandom_range(0, cells - 1), pick_value(35));
        end else begin
          push_item(CMD_LOAD, $urandom_range(0, 65535), pick_value(35));
        end
      end
    end else begin
      while (items_sent - start < n_items) begin
        c  = $urandom_range(0, cells - 1);
        cx = c % grid_w;
        cy = c / grid_w;
        for (int dy = -2; dy <= 2; dy++)
          for (int dx = -2; dx <= 2; dx++)
            if (on_grid(cx + dx, cy + dy))
              push_item(CMD_LOAD, (cy + dy) * grid_w + cx + dx,
                        (dx == 0 && dy == 0) ? pick_value(70) : pick_value(30));
        query_if_ready(c);
        repeat (3) begin
          nx = cx + int'($urandom_range(0, 4)) - 2;
          ny = cy + int'($urandom_range(0, 4)) - 2;
          if (on_grid(nx, ny)) push_item(CMD_LOAD, ny * grid_w + nx, pick_value(30));
          query_if_ready(c);
        end
        repeat (3) begin
          nx = cx + int'($urandom_range(0, 2)) - 1;
          ny = cy + int'($urandom_range(0, 2)) - 1;
          if (on_grid(nx, ny)) query_if_ready(ny * grid_w + nx);
        end
        if (cells < 65536 && $urandom_range(0, 1) == 1)
          push_item(CMD_QUERY, $urandom_range(cells, 65535), VAL_W'($urandom()));
      end
    end
  endtask

  initial begin
    int corner;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_GRID_WIDTH;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_LOAD;
    in_ch.cell_index = '0;
    in_ch.cell_value = '0;
    out_ch.ready     = 1'b0;
    gaps_on          = 1'b0;
    stalls_on        = 1'b0;
    stall_left       = 0;
    grid_w           = 256;
    grid_h           = 256;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, first with the reset grid of 256 by 256: fill the clipped
    // window of the last cell with unknowns around a free corner, then query
    // the highest index, which sits on both clipped edges.
    for (int y = 253; y <= 255; y++)
      for (int x = 253; x <= 255; x++) begin
        corner = y * 256 + x;
        push_item(CMD_LOAD, corner, (corner == 65535) ? VAL_FREE : VAL_UNKNOWN);
      end
    query_if_ready(65535);

    // A 3 by 3 grid around a free centre whose unknown neighbours have only two
    // unknown neighbours each, just below the threshold; turning one corner
    // unknown lifts a neighbour to three and makes the centre a frontier.
    set_grid(REG_W'(3), REG_W'(3));
    push_item(CMD_LOAD, 0, VAL_UNKNOWN);
    push_item(CMD_LOAD, 1, VAL_UNKNOWN);
    push_item(CMD_LOAD, 2, -8'sd128);
    push_item(CMD_LOAD, 3, VAL_UNKNOWN);
    push_item(CMD_LOAD, 4, VAL_FREE);
    push_item(CMD_LOAD, 5, 8'sd127);
    push_item(CMD_LOAD, 6, VAL_FREE);
    push_item(CMD_LOAD, 7, 8'sd1);
    push_item(CMD_LOAD, 8, VAL_FREE);
    query_if_ready(4);
    push_item(CMD_LOAD, 2, VAL_UNKNOWN);
    query_if_ready(4);
    query_if_ready(0);
    query_if_ready(5);
    query_if_ready(8);
    // Indexes just past the grid and at the top of the index range are bad.
    query_if_ready(9);
    query_if_ready(65535);

    // Random part over several settings: out-of-range sides (0 used as 1,
    // above 256 used as 256), single-row and single-column grids, the full
    // grid, and random sizes.
    grid_phase(REG_W'(5),   REG_W'(4),   1'b1, 1'b1, 70);
    grid_phase(REG_W'(0),   REG_W'(0),   1'b0, 1'b1, 30);
    grid_phase(REG_W'(511), REG_W'(2),   1'b1, 1'b1, 70);
    grid_phase(REG_W'(1),   REG_W'(300), 1'b0, 1'b0, 50);
    grid_phase(REG_W'(256), REG_W'(256), 1'b1, 1'b1, 80);
    grid_phase(REG_W'(2),   REG_W'(1),   1'b1, 1'b1, 30);
    grid_phase(REG_W'($urandom_range(1, 12)), REG_W'($urandom_range(1, 12)),
               1'b1, 1'b0, 70);
    grid_phase(REG_W'($urandom_range(0, 511)), REG_W'($urandom_range(0, 511)),
               1'b1, 1'b1, 70);
    // Last part runs with no idling on either side.
    grid_phase(REG_W'(7),   REG_W'(9),   1'b0, 1'b0, 80);

    settle();
    $display("Sent %0d items, %0d of them queries, over %0d grid settings",
             items_sent, queries_sent, settings_run);
    $display("including clamped sides, edge and corner windows and bad indexes.");
    if (mismatches == 0) begin
      $display("occupancy_frontier_cell_test_tb: done, clean");
    end else begin
      $display("occupancy_frontier_cell_test_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: occupancy_frontier_cell_test.f
rtl/ofc_pkg.sv
rtl/ofc_in_if.sv
rtl/ofc_out_if.sv
rtl/ofc_cell_mem.sv
rtl/ofc_divider.sv
rtl/ofc_frontier_eval.sv
rtl/occupancy_frontier_cell_test.sv
rtl/ofc_checker.sv
tb/ofc_frontier_checker.sv
tb/occupancy_frontier_cell_test_tb.sv
